// File: rtl/tkm_pkg.sv
`default_nettype none

package tkm_pkg;

	localparam int STREAM_W  = 4;
	localparam int STAMP_W   = 64;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 64;

	// request function codes
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_END_LIMIT_ON = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_TIME     = 1'b1;

	typedef struct packed {
		logic                func;
		logic [STREAM_W-1:0] stream;
		logic [STAMP_W-1:0]  stamp;
		logic                has_next;
	} req_t;

	typedef struct packed {
		logic [STREAM_W-1:0] head_stream;
		logic [STAMP_W-1:0]  head_stamp;
		logic                empty_res;
	} res_t;

	// one list entry held by a cell
	typedef struct packed {
		logic [STREAM_W-1:0] id;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic upd;       // list changes at this edge
		logic load;      // 1 load, 0 advance
		logic reinsert;  // advance: head goes back into the list
	} ctl_t;

endpackage

`default_nettype wire

// File: rtl/tkm_cell.sv
`default_nettype none

module tkm_cell (
	input  wire              clk,
	input  tkm_pkg::ctl_t    ctl,
	input  tkm_pkg::entry_t  new_entry,
	input  tkm_pkg::entry_t  left_entry,
	input  tkm_pkg::entry_t  right_entry,
	input  wire              left_flag,
	input  wire              right_flag,
	input  wire              occ,
	input  wire              lead,
	output logic             flag,
	output tkm_pkg::entry_t  entry
);
	import tkm_pkg::*;

	entry_t entry_q;
	entry_t entry_nxt;

	// flag: the incoming entry belongs at or ahead of this slot
	// (load: after equal stamps, advance: ahead of equal stamps)
	always_comb begin
		if (!occ) begin
			flag = 1'b1;
		end else if (ctl.load) begin
			flag = entry_q.stamp > new_entry.stamp;
		end else begin
			flag = entry_q.stamp >= new_entry.stamp;
		end
	end

	always_comb begin
		entry_nxt = entry_q;
		if (ctl.load) begin
			if (flag) begin
				entry_nxt = left_flag ? left_entry : new_entry;
			end
		end else if (!ctl.reinsert || !right_flag) begin
			// list slides toward the head
			entry_nxt = right_entry;
		end else if (lead || !flag) begin
			entry_nxt = new_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			entry_q <= entry_nxt;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// File: rtl/timestamp_kway_merge_core.sv
`default_nettype none

// Channel   Dir  Handshake               Payload
// req       in   req_valid / req_ready   tkm_pkg::req_t (func, stream, stamp, has_next)
// res       out  res_valid / res_ready   tkm_pkg::res_t (head_stream, head_stamp, empty_res)
// cfg       in   cfg_we                  cfg_index, cfg_data
//
// For an accepted request the whole ordered list updates together, with
// every cell comparing its own stamp and taking from its left or right neighbor.
// One request per cycle is sustained while res_ready stays high.
// The response shows the head cell and whether the stream count is zero, directly from registers.
// A new request is taken in the cycle its predecessor's response leaves.
// Reset clears the stream count, configuration and response valid; cell contents
// are left undefined since only cells below the count are ever read.

module timestamp_kway_merge_core #(
	parameter int MAX_STREAMS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 req_valid,
	output logic                                req_ready,
	input  tkm_pkg::req_t                       req,
	output logic                                res_valid,
	input  wire                                 res_ready,
	output tkm_pkg::res_t                       res,
	input  wire                                 cfg_we,
	input  wire [tkm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [tkm_pkg::CFG_W-1:0]            cfg_data
);
	import tkm_pkg::*;

	localparam int CNT_W = $clog2(MAX_STREAMS + 1);

	logic               end_limit_on_q;
	logic [STAMP_W-1:0] win_end_q;
	logic [CNT_W-1:0]   count_q;
	logic               res_valid_q;

	logic   req_acc;
	logic   full;
	logic   past_end;
	ctl_t   ctl;
	entry_t new_entry;

	logic   [MAX_STREAMS-1:0] cell_flag;
	logic   [MAX_STREAMS-1:0] cell_left_flag;
	logic   [MAX_STREAMS-1:0] cell_right_flag;
	logic   [MAX_STREAMS-1:0] cell_occ;
	entry_t                   cell_entry [MAX_STREAMS];
	entry_t                   cell_left  [MAX_STREAMS];
	entry_t                   cell_right [MAX_STREAMS];

	// a request waits only while the previous response is still held
	assign req_ready = !res_valid_q || res_ready;
	assign req_acc   = req_valid && req_ready;

	assign full     = count_q == CNT_W'(MAX_STREAMS);
	assign past_end = end_limit_on_q && (req.stamp > win_end_q);

	// load into a full list and advance on an empty list leave it untouched
	always_comb begin
		ctl.load     = req.func == FUNC_LOAD;
		ctl.reinsert = req.has_next && !past_end;
		ctl.upd      = req_acc && (ctl.load ? !full : (count_q != '0));
	end

	// on advance the head stream's id travels with its next stamp
	assign new_entry.id    = ctl.load ? req.stream : cell_entry[0].id;
	assign new_entry.stamp = req.stamp;

	for (genvar i = 0; i < MAX_STREAMS; i++) begin : g_cell
		assign cell_occ[i] = CNT_W'(i) < count_q;

		if (i == 0) begin : g_first
			assign cell_left_flag[i] = 1'b0;
			assign cell_left[i]      = cell_entry[i];
		end else begin : g_mid
			assign cell_left_flag[i] = cell_flag[i-1];
			assign cell_left[i]      = cell_entry[i-1];
		end

		if (i == MAX_STREAMS - 1) begin : g_last
			// beyond the end acts as an empty slot
			assign cell_right_flag[i] = 1'b1;
			assign cell_right[i]      = cell_entry[i];
		end else begin : g_inner
			assign cell_right_flag[i] = cell_flag[i+1];
			assign cell_right[i]      = cell_entry[i+1];
		end

		tkm_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (cell_left[i]),
			.right_entry (cell_right[i]),
			.left_flag   (cell_left_flag[i]),
			.right_flag  (cell_right_flag[i]),
			.occ         (cell_occ[i]),
			.lead        (i == 0),
			.flag        (cell_flag[i]),
			.entry       (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_limit_on_q <= 1'b0;
			win_end_q      <= '0;
			count_q        <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_END_LIMIT_ON: end_limit_on_q <= cfg_data[0];
					REG_END_TIME:     win_end_q      <= cfg_data;
					default:          ;
				endcase
			end
			if (ctl.upd) begin
				if (ctl.load) begin
					count_q <= count_q + CNT_W'(1);
				end else if (!ctl.reinsert) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
			if (req_acc) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

	always_comb begin
		if (count_q != '0) begin
			res.head_stream = cell_entry[0].id;
			res.head_stamp  = cell_entry[0].stamp;
			res.empty_res   = 1'b0;
		end else begin
			res.head_stream = '0;
			res.head_stamp  = '0;
			res.empty_res   = 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tkm_checker.sv
`default_nettype none

module tkm_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            req_valid,
	input wire            req_ready,
	input wire            res_valid,
	input wire            res_ready,
	input tkm_pkg::res_t  res
);
	import tkm_pkg::*;

	// a held response stays until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("response dropped while stalled");

	// every accepted request yields a response next cycle
	a_req_res: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> res_valid)
		else $error("no response after request");

	// no request is taken while a response waits
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !req_ready)
		else $error("request taken over pending response");

	// an empty list reports zero head fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.empty_res |-> (res.head_stream == '0) && (res.head_stamp == '0))
		else $error("empty response with nonzero head");

endmodule

bind timestamp_kway_merge_core tkm_checker u_tkm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire
